@@ hw/rtl/ei_rate_model_rk4_step_assert.svh @@
// Assertion macros shared by the checker of the rate model block
`ifndef EI_RATE_MODEL_RK4_STEP_ASSERT_SVH
`define EI_RATE_MODEL_RK4_STEP_ASSERT_SVH

// check a property at every rising edge outside reset
`define ERK4_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("erk4 assertion failed");

// check that a signal holds in the cycle after a condition
`define ERK4_ASSERT_HOLD(lbl, cond, sig) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> $stable(sig)) \
    else $error("erk4 hold assertion failed");

`endif

@@ hw/rtl/erk4_pkg.sv @@
// Types, constants and helper functions of the rate model block
`timescale 1ns / 1ps
package erk4_pkg;

  localparam int SW = 32;
  localparam int CW = 16;
  localparam int CF = CW - 4;
  localparam int SF = SW - 8;
  localparam int RF = 16;
  localparam int NV = 3;
  localparam int MA = 24;
  localparam int MB = 36;
  localparam int PW = MA + MB;
  localparam int MW = 40;
  localparam int KW = 34;
  localparam int AW = 36;
  localparam int SIXTH_Q24 = 2796203;
  localparam int SIXTH_FRAC = 24;
  localparam int STAGE_OPS = 14;
  localparam int FINAL_OPS = 9;
  localparam int NUM_REGS = 8;

  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SW - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  typedef enum logic [2:0] {
    REG_COUPLING = 3'd0,
    REG_THRESH   = 3'd1,
    REG_GAINS    = 3'd2,
    REG_RATES    = 3'd3,
    REG_DECAY    = 3'd4,
    REG_SCALE    = 3'd5,
    REG_DECIM    = 3'd6,
    REG_INIT     = 3'd7
  } reg_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_INIT,
    OP_MJEE, OP_MJEI, OP_MJIE, OP_MJII, OP_MGA,
    OP_SUM, OP_THR, OP_MSE, OP_MSI, OP_TRF,
    OP_MRE, OP_MRI, OP_MRA, OP_STG,
    OP_MFE, OP_MFI, OP_MFA, OP_UPD,
    OP_MDE, OP_MDI, OP_MNE, OP_MNI, OP_NSE
  } op_e;

  typedef struct packed {
    logic [63:0] coupling;
    logic [63:0] thresh;
    logic [47:0] gains;
    logic [47:0] rates;
    logic [15:0] decay;
    logic [15:0] scale;
    logic [15:0] decim;
    logic [47:0] init;
  } cfg_t;

  typedef struct packed {
    op_e        op;
    logic [1:0] stage;
    logic       capture;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic emit;
  } status_t;

  function automatic logic signed [SW-1:0] sat(input logic signed [63:0] x);
    if (x > SAT_HI) return SW'(SAT_HI);
    if (x < SAT_LO) return SW'(SAT_LO);
    return SW'(x);
  endfunction

  function automatic logic signed [SW-1:0] coef_to_state(input logic [CW-1:0] c);
    return {{(SW - CW - (SF - CF)){c[CW-1]}}, c, {(SF - CF){1'b0}}};
  endfunction

  function automatic op_e stage_op(input logic [3:0] idx);
    op_e op;
    case (idx)
      4'd0:    op = OP_MJEE;
      4'd1:    op = OP_MJEI;
      4'd2:    op = OP_MJIE;
      4'd3:    op = OP_MJII;
      4'd4:    op = OP_MGA;
      4'd5:    op = OP_SUM;
      4'd6:    op = OP_THR;
      4'd7:    op = OP_MSE;
      4'd8:    op = OP_MSI;
      4'd9:    op = OP_TRF;
      4'd10:   op = OP_MRE;
      4'd11:   op = OP_MRI;
      4'd12:   op = OP_MRA;
      4'd13:   op = OP_STG;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic op_e final_op(input logic [3:0] idx);
    op_e op;
    case (idx)
      4'd0:    op = OP_MFE;
      4'd1:    op = OP_MFI;
      4'd2:    op = OP_MFA;
      4'd3:    op = OP_UPD;
      4'd4:    op = OP_MDE;
      4'd5:    op = OP_MDI;
      4'd6:    op = OP_MNE;
      4'd7:    op = OP_MNI;
      4'd8:    op = OP_NSE;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

@@ hw/rtl/erk4_regs.sv @@
// Configuration register file of the rate model block
`timescale 1ns / 1ps
module erk4_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [63:0]          cfg_data_i,
  output erk4_pkg::cfg_t       cfg_o
);

  erk4_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{decim: 16'd1, default: '0};
    end else if (cfg_valid_i) begin
      case (erk4_pkg::reg_e'(cfg_index_i))
        erk4_pkg::REG_COUPLING: cfg_q.coupling <= cfg_data_i;
        erk4_pkg::REG_THRESH:   cfg_q.thresh   <= cfg_data_i;
        erk4_pkg::REG_GAINS:    cfg_q.gains    <= cfg_data_i[47:0];
        erk4_pkg::REG_RATES:    cfg_q.rates    <= cfg_data_i[47:0];
        erk4_pkg::REG_DECAY:    cfg_q.decay    <= cfg_data_i[15:0];
        erk4_pkg::REG_SCALE:    cfg_q.scale    <= cfg_data_i[15:0];
        erk4_pkg::REG_DECIM:    cfg_q.decim    <= cfg_data_i[15:0];
        erk4_pkg::REG_INIT:     cfg_q.init     <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/erk4_dp.sv @@
// Datapath of the rate model block: state, shared multiplier and step registers
`timescale 1ns / 1ps
module erk4_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  erk4_pkg::cfg_t                    cfg_i,
  input  erk4_pkg::cmd_t                    cmd_i,
  output erk4_pkg::status_t                 status_o,
  input  logic signed [15:0]                draw_e_i,
  input  logic signed [15:0]                draw_i_i,
  output logic signed [erk4_pkg::SW-1:0]    rate_e_o,
  output logic signed [erk4_pkg::SW-1:0]    rate_i_o,
  output logic signed [erk4_pkg::SW-1:0]    adaptation_o,
  output logic signed [erk4_pkg::SW-1:0]    noise_e_o,
  output logic signed [erk4_pkg::SW-1:0]    noise_i_o
);

  localparam int SW = erk4_pkg::SW;
  localparam int CW = erk4_pkg::CW;
  localparam int MA = erk4_pkg::MA;
  localparam int MB = erk4_pkg::MB;
  localparam int PW = erk4_pkg::PW;
  localparam int MW = erk4_pkg::MW;
  localparam int KW = erk4_pkg::KW;
  localparam int AW = erk4_pkg::AW;
  localparam int NV = erk4_pkg::NV;
  localparam logic signed [MA-1:0] SIXTH = MA'(erk4_pkg::SIXTH_Q24);

  logic signed [SW-1:0] y_q [NV];
  logic signed [SW-1:0] ne_q, ni_q;
  logic [15:0]          cnt_q;
  logic                 emit_q;

  logic signed [SW-1:0] p_q [NV];
  logic signed [MW-1:0] m_q [5];
  logic signed [SW-1:0] ae_q, ai_q, fa_q, xe_q, xi_q, fe_q, fi_q;
  logic signed [MW-1:0] te_q, ti_q;
  logic signed [KW-1:0] k_q [NV];
  logic signed [AW-1:0] acc_q [NV];
  logic signed [MW-1:0] inc_q [NV];
  logic signed [MW-1:0] nde_q, ndi_q, nwe_q, nwi_q;
  logic signed [15:0]   de_q, di_q;
  logic signed [SW-1:0] out_q [5];

  logic signed [CW-1:0] jee, jei, jie, jii, slope_e, slope_i, gain_a;
  logic signed [CW:0]   rate_e, rate_i, rate_a, decay, scale;
  logic signed [SW-1:0] drv_e, drv_i, thr_e, thr_i;
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod, sh12, sh16, sh24;
  logic signed [63:0]   ae_sum, ai_sum;
  logic [16:0]          cnt_inc;

  assign jee     = cfg_i.coupling[15:0];
  assign jei     = cfg_i.coupling[31:16];
  assign jie     = cfg_i.coupling[47:32];
  assign jii     = cfg_i.coupling[63:48];
  assign drv_e   = erk4_pkg::coef_to_state(cfg_i.thresh[15:0]);
  assign drv_i   = erk4_pkg::coef_to_state(cfg_i.thresh[31:16]);
  assign thr_e   = erk4_pkg::coef_to_state(cfg_i.thresh[47:32]);
  assign thr_i   = erk4_pkg::coef_to_state(cfg_i.thresh[63:48]);
  assign slope_e = cfg_i.gains[15:0];
  assign slope_i = cfg_i.gains[31:16];
  assign gain_a  = cfg_i.gains[47:32];
  assign rate_e  = $signed({1'b0, cfg_i.rates[15:0]});
  assign rate_i  = $signed({1'b0, cfg_i.rates[31:16]});
  assign rate_a  = $signed({1'b0, cfg_i.rates[47:32]});
  assign decay   = $signed({1'b0, cfg_i.decay});
  assign scale   = $signed({1'b0, cfg_i.scale});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      erk4_pkg::OP_MJEE: begin mul_a = MA'(jee);     mul_b = MB'(p_q[0]); end
      erk4_pkg::OP_MJEI: begin mul_a = MA'(jei);     mul_b = MB'(p_q[1]); end
      erk4_pkg::OP_MJIE: begin mul_a = MA'(jie);     mul_b = MB'(p_q[0]); end
      erk4_pkg::OP_MJII: begin mul_a = MA'(jii);     mul_b = MB'(p_q[1]); end
      erk4_pkg::OP_MGA:  begin mul_a = MA'(gain_a);  mul_b = MB'(p_q[0]); end
      erk4_pkg::OP_MSE:  begin mul_a = MA'(slope_e); mul_b = MB'(xe_q);   end
      erk4_pkg::OP_MSI:  begin mul_a = MA'(slope_i); mul_b = MB'(xi_q);   end
      erk4_pkg::OP_MRE:  begin mul_a = MA'(rate_e);  mul_b = MB'(fe_q);   end
      erk4_pkg::OP_MRI:  begin mul_a = MA'(rate_i);  mul_b = MB'(fi_q);   end
      erk4_pkg::OP_MRA:  begin mul_a = MA'(rate_a);  mul_b = MB'(fa_q);   end
      erk4_pkg::OP_MFE:  begin mul_a = SIXTH;        mul_b = MB'(acc_q[0]); end
      erk4_pkg::OP_MFI:  begin mul_a = SIXTH;        mul_b = MB'(acc_q[1]); end
      erk4_pkg::OP_MFA:  begin mul_a = SIXTH;        mul_b = MB'(acc_q[2]); end
      erk4_pkg::OP_MDE:  begin mul_a = MA'(decay);   mul_b = MB'(ne_q);   end
      erk4_pkg::OP_MDI:  begin mul_a = MA'(decay);   mul_b = MB'(ni_q);   end
      erk4_pkg::OP_MNE:  begin mul_a = MA'(scale);   mul_b = MB'(de_q);   end
      erk4_pkg::OP_MNI:  begin mul_a = MA'(scale);   mul_b = MB'(di_q);   end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;
  assign sh12 = prod >>> erk4_pkg::CF;
  assign sh16 = prod >>> erk4_pkg::RF;
  assign sh24 = prod >>> erk4_pkg::SIXTH_FRAC;

  assign ae_sum = 64'(m_q[0]) - 64'(m_q[1]) + 64'(drv_e) - 64'(p_q[2]) + 64'(ne_q);
  assign ai_sum = 64'(m_q[2]) - 64'(m_q[3]) + 64'(drv_i) + 64'(ni_q);
  assign cnt_inc = {1'b0, cnt_q} + 17'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < NV; v++) y_q[v] <= '0;
      ne_q   <= '0;
      ni_q   <= '0;
      cnt_q  <= '0;
      emit_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        erk4_pkg::OP_LOAD: begin
          y_q[0] <= erk4_pkg::coef_to_state(cfg_i.init[15:0]);
          y_q[1] <= erk4_pkg::coef_to_state(cfg_i.init[31:16]);
          y_q[2] <= erk4_pkg::coef_to_state(cfg_i.init[47:32]);
          ne_q   <= '0;
          ni_q   <= '0;
          cnt_q  <= '0;
          emit_q <= 1'b1;
        end
        erk4_pkg::OP_UPD: begin
          for (int v = 0; v < NV; v++) y_q[v] <= erk4_pkg::sat(64'(y_q[v]) + 64'(inc_q[v]));
        end
        erk4_pkg::OP_NSE: begin
          ne_q <= erk4_pkg::sat(64'(nde_q) + 64'(nwe_q));
          ni_q <= erk4_pkg::sat(64'(ndi_q) + 64'(nwi_q));
          if (cnt_inc >= {1'b0, cfg_i.decim}) begin
            cnt_q  <= '0;
            emit_q <= 1'b1;
          end else begin
            cnt_q  <= cnt_inc[15:0];
            emit_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      de_q <= draw_e_i;
      di_q <= draw_i_i;
    end
    if (cmd_i.load_out) begin
      out_q[0] <= y_q[0];
      out_q[1] <= y_q[1];
      out_q[2] <= y_q[2];
      out_q[3] <= ne_q;
      out_q[4] <= ni_q;
    end
    case (cmd_i.op)
      erk4_pkg::OP_INIT: for (int v = 0; v < NV; v++) p_q[v] <= y_q[v];
      erk4_pkg::OP_MJEE: m_q[0] <= MW'(sh12);
      erk4_pkg::OP_MJEI: m_q[1] <= MW'(sh12);
      erk4_pkg::OP_MJIE: m_q[2] <= MW'(sh12);
      erk4_pkg::OP_MJII: m_q[3] <= MW'(sh12);
      erk4_pkg::OP_MGA:  m_q[4] <= MW'(sh12);
      erk4_pkg::OP_SUM: begin
        ae_q <= erk4_pkg::sat(ae_sum);
        ai_q <= erk4_pkg::sat(ai_sum);
        fa_q <= erk4_pkg::sat(64'(m_q[4]) - 64'(p_q[2]));
      end
      erk4_pkg::OP_THR: begin
        xe_q <= (ae_q > thr_e) ? erk4_pkg::sat(64'(ae_q) - 64'(thr_e)) : '0;
        xi_q <= (ai_q > thr_i) ? erk4_pkg::sat(64'(ai_q) - 64'(thr_i)) : '0;
      end
      erk4_pkg::OP_MSE:  te_q <= MW'(sh12);
      erk4_pkg::OP_MSI:  ti_q <= MW'(sh12);
      erk4_pkg::OP_TRF: begin
        fe_q <= erk4_pkg::sat(64'(te_q) - 64'(p_q[0]));
        fi_q <= erk4_pkg::sat(64'(ti_q) - 64'(p_q[1]));
      end
      erk4_pkg::OP_MRE:  k_q[0] <= KW'(sh16);
      erk4_pkg::OP_MRI:  k_q[1] <= KW'(sh16);
      erk4_pkg::OP_MRA:  k_q[2] <= KW'(sh16);
      erk4_pkg::OP_STG: begin
        for (int v = 0; v < NV; v++) begin
          if (cmd_i.stage == 2'd0) begin
            acc_q[v] <= AW'(k_q[v]);
          end else if (cmd_i.stage == 2'd3) begin
            acc_q[v] <= acc_q[v] + AW'(k_q[v]);
          end else begin
            acc_q[v] <= acc_q[v] + (AW'(k_q[v]) <<< 1);
          end
          if (cmd_i.stage[1]) begin
            p_q[v] <= erk4_pkg::sat(64'(y_q[v]) + 64'(k_q[v]));
          end else begin
            p_q[v] <= erk4_pkg::sat(64'(y_q[v]) + 64'(k_q[v] >>> 1));
          end
        end
      end
      erk4_pkg::OP_MFE:  inc_q[0] <= MW'(sh24);
      erk4_pkg::OP_MFI:  inc_q[1] <= MW'(sh24);
      erk4_pkg::OP_MFA:  inc_q[2] <= MW'(sh24);
      erk4_pkg::OP_MDE:  nde_q <= MW'(sh16);
      erk4_pkg::OP_MDI:  ndi_q <= MW'(sh16);
      erk4_pkg::OP_MNE:  nwe_q <= MW'(prod);
      erk4_pkg::OP_MNI:  nwi_q <= MW'(prod);
      default: ;
    endcase
  end

  assign status_o.emit = emit_q;
  assign rate_e_o      = out_q[0];
  assign rate_i_o      = out_q[1];
  assign adaptation_o  = out_q[2];
  assign noise_e_o     = out_q[3];
  assign noise_i_o     = out_q[4];

endmodule

@@ hw/rtl/erk4_ctrl.sv @@
// Controller of the rate model block: step sequencer and output handshake
`timescale 1ns / 1ps
module erk4_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                restart_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output erk4_pkg::cmd_t      cmd_o,
  input  erk4_pkg::status_t   status_i
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_INIT  = 6'b000100,
    ST_STAGE = 6'b001000,
    ST_FINAL = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] idx_q, idx_d;
  logic [1:0] stg_q, stg_d;
  logic       out_valid_q, out_valid_d;
  logic       load_out;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    stg_d         = stg_q;
    load_out      = 1'b0;
    cmd_o.op      = erk4_pkg::OP_NONE;
    cmd_o.stage   = stg_q;
    cmd_o.capture = in_valid_i && in_ready_o;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = restart_i ? ST_LOAD : ST_INIT;
        end
      end
      ST_LOAD: begin
        cmd_o.op = erk4_pkg::OP_LOAD;
        state_d  = ST_DONE;
      end
      ST_INIT: begin
        cmd_o.op = erk4_pkg::OP_INIT;
        idx_d    = '0;
        stg_d    = '0;
        state_d  = ST_STAGE;
      end
      ST_STAGE: begin
        cmd_o.op = erk4_pkg::stage_op(idx_q);
        if (idx_q == 4'(erk4_pkg::STAGE_OPS - 1)) begin
          idx_d = '0;
          if (stg_q == 2'd3) begin
            state_d = ST_FINAL;
          end else begin
            stg_d = stg_q + 2'd1;
          end
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end
      ST_FINAL: begin
        cmd_o.op = erk4_pkg::final_op(idx_q);
        if (idx_q == 4'(erk4_pkg::FINAL_OPS - 1)) begin
          idx_d   = '0;
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end
      ST_DONE: begin
        if (!status_i.emit) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    cmd_o.load_out = load_out;
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      stg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      stg_q       <= stg_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hw/rtl/ei_rate_model_rk4_step.sv @@
// Top level of the excitatory/inhibitory rate model step block
// Each input item is one time step: restart_i, draw_e_i and draw_i_i.
// in_valid_i/in_ready_o take an item; in_ready_o is high only while the
// sequencer is idle. A step item runs one Runge-Kutta step through a single
// shared multiplier: a load of the stage inputs, four stages of 14
// operations, then the state update, the noise update and the sample count,
// and a hand-off of the result. A restart item loads the initial state and
// then hands off its result.
// Results appear on out_valid_o/out_ready_i with rate_e_o,
// rate_i_o, adaptation_o, noise_e_o and noise_i_o, one result per restart
// and one per decimation steps. A finished result sits in an output
// register; the next item is taken while it waits, and the block holds in
// its last cycle only if a second result is ready before the first is taken.
// cfg_valid_i/cfg_ready_o write register cfg_index_i with cfg_data_i;
// cfg_ready_o stays high. Reset clears state and registers, sets the
// decimation to 1 and leaves the output channel empty.
`timescale 1ns / 1ps
module ei_rate_model_rk4_step (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           restart_i,
  input  logic signed [15:0]             draw_e_i,
  input  logic signed [15:0]             draw_i_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [erk4_pkg::SW-1:0] rate_e_o,
  output logic signed [erk4_pkg::SW-1:0] rate_i_o,
  output logic signed [erk4_pkg::SW-1:0] adaptation_o,
  output logic signed [erk4_pkg::SW-1:0] noise_e_o,
  output logic signed [erk4_pkg::SW-1:0] noise_i_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [2:0]                     cfg_index_i,
  input  logic [63:0]                    cfg_data_i
);

  erk4_pkg::cfg_t    cfg;
  erk4_pkg::cmd_t    cmd;
  erk4_pkg::status_t status;

  erk4_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  erk4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  erk4_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .status_o     (status),
    .draw_e_i     (draw_e_i),
    .draw_i_i     (draw_i_i),
    .rate_e_o     (rate_e_o),
    .rate_i_o     (rate_i_o),
    .adaptation_o (adaptation_o),
    .noise_e_o    (noise_e_o),
    .noise_i_o    (noise_i_o)
  );

endmodule

@@ hw/rtl/erk4_checker.sv @@
// Port-level checker of the rate model block and its bind
`timescale 1ns / 1ps
`include "ei_rate_model_rk4_step_assert.svh"
module erk4_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           restart_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic signed [erk4_pkg::SW-1:0] rate_e_o,
  input logic signed [erk4_pkg::SW-1:0] noise_i_o
);

  `ERK4_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)
  `ERK4_ASSERT_HOLD(a_out_stable, out_valid_o && !out_ready_i, rate_e_o)
  `ERK4_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o)
  `ERK4_ASSERT(a_restart_emits, in_valid_i && in_ready_o && restart_i && !out_valid_o |-> ##3 out_valid_o)
  `ERK4_ASSERT_HOLD(a_noise_stable, out_valid_o && !out_ready_i, noise_i_o)

endmodule

bind ei_rate_model_rk4_step erk4_checker u_chk (.*);

@@ dv/tb.sv @@
// Testbench for the E/I rate model step block: predicts and checks every output item
`timescale 1ns / 1ps
module tb;
  import erk4_pkg::*;

  typedef longint vec_t[3];

  typedef struct {
    logic               restart;
    logic signed [15:0] draw_e;
    logic signed [15:0] draw_i;
  } step_t;

  typedef struct {
    logic signed [31:0] rate_e;
    logic signed [31:0] rate_i;
    logic signed [31:0] adapt;
    logic signed [31:0] noise_e;
    logic signed [31:0] noise_i;
  } sample_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic restart_i = 1'b0;
  logic signed [15:0] draw_e_i = '0;
  logic signed [15:0] draw_i_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [SW-1:0] rate_e_o, rate_i_o, adaptation_o, noise_e_o, noise_i_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  reg_e cfg_index_i = REG_COUPLING;
  logic [63:0] cfg_data_i = '0;

  ei_rate_model_rk4_step i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .restart_i, .draw_e_i, .draw_i_i,
    .out_valid_o, .out_ready_i, .rate_e_o, .rate_i_o, .adaptation_o, .noise_e_o,
    .noise_i_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  step_t   pending_steps[$];
  sample_t expected_samples[$];
  int      mismatches = 0;
  int      steps_taken = 0;
  int      idle_cycles = 0;
  logic    step_taken = 1'b0;

  logic [63:0] m_coup, m_thr;
  logic [47:0] m_gain, m_rate, m_init;
  logic [15:0] m_decay, m_scale, m_decim;
  longint      s_e, s_i, s_a, n_e, n_i;
  int          step_cnt;

  function automatic longint satv(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint cf(logic [63:0] r, int idx);
    return longint'(signed'(r[idx*16 +: 16]));
  endfunction

  function automatic longint c2s(longint c);
    return c * 4096;
  endfunction

  function automatic longint dt_ratio(int idx);
    return longint'({48'b0, m_rate[idx*16 +: 16]});
  endfunction

  function automatic longint xfer(longint y, longint drive, longint thr, longint slope);
    longint f;
    f = -y;
    if (drive > thr) f += (slope * satv(drive - thr)) >>> 12;
    return satv(f);
  endfunction

  function automatic void slope_at(input vec_t y, output vec_t k);
    longint ae, ai, fe, fi, fa;
    ae = satv(((cf(m_coup, 0) * y[0]) >>> 12) - ((cf(m_coup, 1) * y[1]) >>> 12)
              + c2s(cf(m_thr, 0)) - y[2] + n_e);
    ai = satv(((cf(m_coup, 2) * y[0]) >>> 12) - ((cf(m_coup, 3) * y[1]) >>> 12)
              + c2s(cf(m_thr, 1)) + n_i);
    fe = xfer(y[0], ae, c2s(cf(m_thr, 2)), cf(m_gain, 0));
    fi = xfer(y[1], ai, c2s(cf(m_thr, 3)), cf(m_gain, 1));
    fa = satv(-y[2] + ((cf(m_gain, 2) * y[0]) >>> 12));
    k[0] = (dt_ratio(0) * fe) >>> 16;
    k[1] = (dt_ratio(1) * fi) >>> 16;
    k[2] = (dt_ratio(2) * fa) >>> 16;
  endfunction

  function automatic void advance_model(input step_t st, output bit emitted,
                                        output sample_t smp);
    vec_t y, p, k1, k2, k3, k4;
    longint sum;
    emitted = 1'b0;
    if (st.restart) begin
      s_e = satv(c2s(cf(m_init, 0)));
      s_i = satv(c2s(cf(m_init, 1)));
      s_a = satv(c2s(cf(m_init, 2)));
      n_e = 0;
      n_i = 0;
      step_cnt = 0;
      emitted = 1'b1;
    end else begin
      y[0] = s_e; y[1] = s_i; y[2] = s_a;
      slope_at(y, k1);
      for (int v = 0; v < 3; v++) p[v] = satv(y[v] + (k1[v] >>> 1));
      slope_at(p, k2);
      for (int v = 0; v < 3; v++) p[v] = satv(y[v] + (k2[v] >>> 1));
      slope_at(p, k3);
      for (int v = 0; v < 3; v++) p[v] = satv(y[v] + k3[v]);
      slope_at(p, k4);
      for (int v = 0; v < 3; v++) begin
        sum = k1[v] + 2 * k2[v] + 2 * k3[v] + k4[v];
        y[v] = satv(y[v] + ((sum * SIXTH_Q24) >>> SIXTH_FRAC));
      end
      s_e = y[0]; s_i = y[1]; s_a = y[2];
      n_e = satv(((n_e * longint'(m_decay)) >>> 16) + longint'(m_scale) * longint'(st.draw_e));
      n_i = satv(((n_i * longint'(m_decay)) >>> 16) + longint'(m_scale) * longint'(st.draw_i));
      if (step_cnt + 1 >= int'(m_decim)) begin
        step_cnt = 0;
        emitted = 1'b1;
      end else begin
        step_cnt = (step_cnt + 1) & 16'hFFFF;
      end
    end
    smp.rate_e = s_e[31:0];
    smp.rate_i = s_i[31:0];
    smp.adapt = s_a[31:0];
    smp.noise_e = n_e[31:0];
    smp.noise_i = n_i[31:0];
  endfunction

  // model update and output checking
  always @(posedge clk_i or negedge rst_ni) begin
    sample_t smp, want;
    bit emitted;
    if (!rst_ni) begin
      m_coup = '0; m_thr = '0; m_gain = '0; m_rate = '0; m_init = '0;
      m_decay = '0; m_scale = '0; m_decim = 16'd1;
      s_e = 0; s_i = 0; s_a = 0; n_e = 0; n_i = 0; step_cnt = 0;
      step_taken <= 1'b0;
    end else begin
      step_taken <= in_valid_i && in_ready_o;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_COUPLING: m_coup = cfg_data_i;
          REG_THRESH:   m_thr = cfg_data_i;
          REG_GAINS:    m_gain = cfg_data_i[47:0];
          REG_RATES:    m_rate = cfg_data_i[47:0];
          REG_DECAY:    m_decay = cfg_data_i[15:0];
          REG_SCALE:    m_scale = cfg_data_i[15:0];
          REG_DECIM:    m_decim = cfg_data_i[15:0];
          REG_INIT:     m_init = cfg_data_i[47:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        advance_model('{restart_i, draw_e_i, draw_i_i}, emitted, smp);
        if (emitted) expected_samples.push_back(smp);
        steps_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output item at %0t", $realtime);
        end else begin
          want = expected_samples.pop_front();
          if (want.rate_e !== rate_e_o || want.rate_i !== rate_i_o ||
              want.adapt !== adaptation_o || want.noise_e !== noise_e_o ||
              want.noise_i !== noise_i_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t: exp %h %h %h %h %h got %h %h %h %h %h", $realtime,
                       want.rate_e, want.rate_i, want.adapt, want.noise_e, want.noise_i,
                       rate_e_o, rate_i_o, adaptation_o, noise_e_o, noise_i_o);
          end
        end
      end
    end
  end

  // input driver: bursts and gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk_i) begin
    logic nv;
    step_t st;
    if (rst_ni && !(in_valid_i && !step_taken)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_steps.size() > 0) begin
        st = pending_steps.pop_front();
        restart_i <= st.restart;
        draw_e_i <= st.draw_e;
        draw_i_i <= st.draw_i;
        nv = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
      in_valid_i <= nv;
    end
  end

  // output receiver: stall pattern plus one long hold-off
  int run_left = 0;
  int ready_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk_i) begin
    logic nr;
    if (hold_left > 0) begin
      hold_left--;
      nr = 1'b0;
    end else if (!hold_done && steps_taken >= 400) begin
      hold_done = 1'b1;
      hold_left = 3000;
      nr = 1'b0;
    end else begin
      if (run_left <= 0) begin
        ready_mode = $urandom_range(0, 2);
        run_left = $urandom_range(10, 60);
      end
      run_left--;
      case (ready_mode)
        0: nr = 1'b1;
        1: nr = ($urandom_range(0, 3) != 0);
        default: nr = ($urandom_range(0, 9) < 3);
      endcase
    end
    out_ready_i <= nr;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(reg_e idx, logic [63:0] d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(logic [63:0] coup, logic [63:0] thr, logic [47:0] gain,
                           logic [47:0] rt, logic [15:0] decay, logic [15:0] scale,
                           logic [15:0] decim, logic [47:0] init);
    write_reg(REG_COUPLING, coup);
    write_reg(REG_THRESH, thr);
    write_reg(REG_GAINS, {$urandom, $urandom} & 64'hFFFF_0000_0000_0000 | gain);
    write_reg(REG_RATES, rt);
    write_reg(REG_DECAY, decay);
    write_reg(REG_SCALE, scale);
    write_reg(REG_DECIM, decim);
    write_reg(REG_INIT, init);
  endtask

  task automatic wait_idle();
    while (pending_steps.size() > 0 || in_valid_i || expected_samples.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_step(logic rs, logic signed [15:0] de, logic signed [15:0] di);
    step_t st;
    st.restart = rs;
    st.draw_e = de;
    st.draw_i = di;
    pending_steps.push_back(st);
  endtask

  function automatic logic [15:0] mild_coef();
    return 16'($signed($urandom_range(0, 16383)) - 8192);
  endfunction

  initial begin
    logic [15:0] decim;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_all(64'h8000_7FFF_8000_7FFF, 64'h7FFF_8000_8000_7FFF, 48'h7FFF_8000_7FFF,
              48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'd1, 48'h8000_7FFF_8000);
    add_step(1'b1, 16'sh1234, -16'sh1234);
    add_step(1'b0, 16'sh7FFF, -16'sh8000);
    add_step(1'b0, -16'sh8000, 16'sh7FFF);
    add_step(1'b0, 16'sh0000, 16'sh0000);
    add_step(1'b0, -16'sh0001, 16'sh0001);
    add_step(1'b1, 16'sh7FFF, 16'sh7FFF);
    wait_idle();

    write_all('0, '0, '0, '0, '0, '0, 16'd0, '0);
    add_step(1'b0, 16'sh7FFF, 16'sh7FFF);
    add_step(1'b0, -16'sh8000, -16'sh8000);
    add_step(1'b0, 16'sh0100, -16'sh0100);
    wait_idle();

    write_all(64'h0800_0400_0C00_1400, 64'h0200_0100_F800_0400, 48'h0800_1000_1800,
              48'h0800_1000_2000, 16'hF000, 16'h0400, 16'd5, 48'h0400_0800_0C00);
    add_step(1'b1, 16'sh0000, 16'sh0000);
    add_step(1'b0, 16'sh1000, -16'sh1000);
    add_step(1'b0, -16'sh0800, 16'sh0800);
    add_step(1'b0, 16'sh0400, 16'sh0200);
    wait_idle();
    write_reg(REG_DECIM, 64'd2);
    add_step(1'b0, 16'sh0300, -16'sh0300);
    add_step(1'b0, 16'sh0000, 16'sh0000);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 5) decim = 16'hFFFF;
      else if (ph == 6) decim = 16'd0;
      else decim = 16'($urandom_range(1, 6));
      if (ph % 2 == 0)
        write_all({mild_coef(), mild_coef(), mild_coef(), mild_coef()},
                  {mild_coef(), mild_coef(), mild_coef(), mild_coef()},
                  {mild_coef(), mild_coef(), mild_coef()},
                  {16'($urandom_range(0, 16000)), 16'($urandom_range(0, 16000)),
                   16'($urandom_range(0, 16000))},
                  16'($urandom_range(40000, 65535)), 16'($urandom_range(0, 2000)),
                  decim, {mild_coef(), mild_coef(), mild_coef()});
      else
        write_all({$urandom, $urandom}, {$urandom, $urandom}, 48'({$urandom, $urandom}),
                  48'({$urandom, $urandom}), 16'($urandom), 16'($urandom), decim,
                  48'({$urandom, $urandom}));
      for (int n = 0; n < ((ph == 5) ? 40 : 120); n++)
        add_step((n == 0) || ($urandom_range(0, 99) < ((ph == 5) ? 15 : 4)),
                 16'($urandom), 16'($urandom));
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
